// ----- design/gfsi_pkg.sv -----
// Shared types, codes and constants for the gas and fire shutoff interlock.
`timescale 1ns / 1ps
package gfsi_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned GAS_W   = 12;
    localparam int unsigned MS_W    = 20;
    localparam int unsigned BLINK_W = 12;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned SEC_W   = 11;
    localparam int unsigned ADDR_W  = 2;
    localparam int unsigned DATA_W  = 20;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [GAS_W-1:0]   t_gas;
    typedef logic [MS_W-1:0]    t_ms;
    typedef logic [BLINK_W-1:0] t_blink;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [STAT_W-1:0]  t_status;
    typedef logic [SEC_W-1:0]   t_sec;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [DATA_W-1:0]  t_data;

    // command codes
    localparam t_cmd CMD_TICK      = 3'd0;
    localparam t_cmd CMD_SAMPLE    = 3'd1;
    localparam t_cmd CMD_CLOSE     = 3'd2;
    localparam t_cmd CMD_OPEN      = 3'd3;
    localparam t_cmd CMD_TMR_RESET = 3'd4;
    localparam t_cmd CMD_APP_ON    = 3'd5;
    localparam t_cmd CMD_APP_OFF   = 3'd6;

    // modes
    localparam t_mode MODE_NORMAL = 2'd0;
    localparam t_mode MODE_GAS    = 2'd1;
    localparam t_mode MODE_FIRE   = 2'd2;
    localparam t_mode MODE_APP    = 2'd3;

    // status codes
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_APP_ALERT  = 3'd3;
    localparam t_status ST_APP_TIMER  = 3'd4;
    localparam t_status ST_FIRE_COUNT = 3'd5;

    // config register indexes
    localparam t_addr CFG_GAS_THR   = 2'd0;
    localparam t_addr CFG_FIRE_LIM  = 2'd1;
    localparam t_addr CFG_FAST_BLNK = 2'd2;
    localparam t_addr CFG_SLOW_BLNK = 2'd3;

    // config reset values
    localparam t_gas   GAS_THR_RST   = 12'd1500;
    localparam t_ms    FIRE_LIM_RST  = 20'd300000;
    localparam t_blink FAST_BLNK_RST = 12'd250;
    localparam t_blink SLOW_BLNK_RST = 12'd1000;

    // ms to s: floor(x / 1000) = (x * ceil(2^30 / 1000)) >> 30, exact for x < 2^20
    localparam int unsigned DIV_SHIFT = 30;
    localparam int unsigned RECIP_W   = 21;
    localparam int unsigned PROD_W    = MS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

endpackage

// ----- design/gfsi_if.sv -----
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
interface gfsi_in_if import gfsi_pkg::*; ();
    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_gas   gas_level;
    logic   flame_seen;
    logic   person_present;

    modport source (output valid, cmd, gas_level, flame_seen, person_present, input ready);
    modport sink   (input valid, cmd, gas_level, flame_seen, person_present, output ready);
endinterface

interface gfsi_out_if import gfsi_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    valve_open;
    t_mode   mode;
    t_status status_code;
    t_sec    remaining_s;
    logic    red_led;
    logic    yellow_led;
    logic    green_led;

    modport source (output valid, valve_open, mode, status_code, remaining_s,
                    red_led, yellow_led, green_led, input ready);
    modport sink   (input valid, valve_open, mode, status_code, remaining_s,
                    red_led, yellow_led, green_led, output ready);
endinterface

interface gfsi_cfg_if import gfsi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_addr addr;
    t_data data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- design/gfsi_rem.sv -----
// Remaining whole seconds before fire alarm: (limit - elapsed) / 1000, floored at zero.
`timescale 1ns / 1ps
module gfsi_rem import gfsi_pkg::*; (
    input  t_ms  i_limit,
    input  t_ms  i_elapsed,
    output t_sec o_sec
);
    t_ms                diff;
    logic [PROD_W-1:0]  prod;

    always_comb begin
        diff = (i_elapsed < i_limit) ? (i_limit - i_elapsed) : '0;
        prod = PROD_W'(diff) * PROD_W'(RECIP_1000);
        o_sec = prod[DIV_SHIFT +: SEC_W];
    end
endmodule

// ----- design/gas_fire_shutoff_interlock.sv -----
// Top level: gas valve and fire safety interlock with request/result register stages.
//
//  channel  | dir | payload                                              | handshake
//  i_req    | in  | cmd, gas_level, flame_seen, person_present           | valid/ready
//  o_rsp    | out | valve_open, mode, status_code, remaining_s, 3 lamps  | valid/ready
//  i_cfg    | in  | addr (register index), data                          | valid/ready
//
// One request per cycle unless o_rsp stalls; path: request register, result register, o_rsp.
// Request register feeds the state update; the result register holds the answer.
// A stalled o_rsp holds the result; i_req keeps accepting while the request slot can drain.
// i_cfg is always ready. Synchronous active-low reset loads default config, clears state.
`timescale 1ns / 1ps
`default_nettype none
module gas_fire_shutoff_interlock import gfsi_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gfsi_in_if.sink     i_req,
    gfsi_out_if.source  o_rsp,
    gfsi_cfg_if.sink    i_cfg
);
    // config
    t_gas   r_gas_thr;
    t_ms    r_fire_lim;
    t_blink r_fast_ms;
    t_blink r_slow_ms;

    // request register
    logic   r_in_vld;
    t_cmd   r_cmd;
    t_gas   r_gas_in;
    logic   r_flame_in;
    logic   r_pres_in;

    // interlock state
    t_mode  r_mode,    n_mode;
    logic   r_valve,   n_valve;
    logic   r_tmr_on,  n_tmr_on;
    logic   r_app,     n_app;
    t_ms    r_elapsed, n_elapsed;
    t_gas   r_gas,     n_gas;
    logic   r_flame,   n_flame;
    logic   r_pres,    n_pres;
    t_blink r_fast,    n_fast;
    t_blink r_slow,    n_slow;
    logic   r_red,     n_red;
    logic   r_yel,     n_yel;

    // result register
    logic    r_out_vld;
    logic    r_o_valve;
    t_mode   r_o_mode;
    t_status r_o_stat;
    t_sec    r_o_sec;
    logic    r_o_red;
    logic    r_o_yel;
    logic    r_o_grn;

    t_status n_stat;
    t_sec    rem_sec;
    logic    n_red_led, n_yel_led, n_grn_led;
    logic    fire_cnt;
    t_blink  cnt_inc;
    logic    raised;
    logic    adv;

    assign adv         = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || adv;
    assign i_cfg.ready = 1'b1;

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_valve   = r_valve;
        n_tmr_on  = r_tmr_on;
        n_app     = r_app;
        n_elapsed = r_elapsed;
        n_gas     = r_gas;
        n_flame   = r_flame;
        n_pres    = r_pres;
        n_fast    = r_fast;
        n_slow    = r_slow;
        n_red     = r_red;
        n_yel     = r_yel;
        cnt_inc   = '0;
        raised    = 1'b0;

        unique case (r_cmd)
            CMD_TICK: begin
                if (r_tmr_on && r_elapsed < r_fire_lim) begin
                    n_elapsed = r_elapsed + 20'd1;
                end
                if (r_mode == MODE_GAS || r_mode == MODE_FIRE) begin
                    cnt_inc = r_fast + 12'd1;
                    if (cnt_inc >= r_fast_ms) begin
                        n_fast = '0;
                        n_red  = !r_red;
                    end else begin
                        n_fast = cnt_inc;
                    end
                end else if (r_mode == MODE_NORMAL && !r_app && r_tmr_on) begin
                    cnt_inc = r_slow + 12'd1;
                    if (cnt_inc >= r_slow_ms) begin
                        n_slow = '0;
                        n_yel  = !r_yel;
                    end else begin
                        n_slow = cnt_inc;
                    end
                end
            end
            CMD_SAMPLE: begin
                n_gas   = r_gas_in;
                n_flame = r_flame_in;
                n_pres  = r_pres_in;
                if (r_mode == MODE_GAS || r_mode == MODE_FIRE) begin
                    n_valve = 1'b0;
                end else if (r_gas_in > r_gas_thr) begin
                    n_mode  = MODE_GAS;
                    n_valve = 1'b0;
                end else begin
                    if (r_flame_in && !r_pres_in && !r_app) begin
                        if (!r_tmr_on) begin
                            n_elapsed = '0;
                            n_tmr_on  = 1'b1;
                        end else if (r_elapsed >= r_fire_lim) begin
                            n_mode  = MODE_FIRE;
                            n_valve = 1'b0;
                            raised  = 1'b1;
                        end
                    end else begin
                        n_tmr_on = 1'b0;
                    end
                    if (!raised) begin
                        if (r_mode == MODE_APP) begin
                            n_valve = 1'b0;
                        end else begin
                            n_mode  = MODE_NORMAL;
                            n_valve = 1'b1;
                        end
                    end
                end
            end
            CMD_CLOSE: begin
                n_valve = 1'b0;
                n_mode  = MODE_APP;
            end
            CMD_OPEN: begin
                if (r_mode == MODE_GAS) begin
                    if (r_gas < r_gas_thr) begin
                        n_mode = MODE_NORMAL;
                    end
                end else if (r_mode != MODE_FIRE) begin
                    n_mode = MODE_NORMAL;
                end
            end
            CMD_TMR_RESET: begin
                if (r_mode == MODE_FIRE) begin
                    if (!r_flame || r_pres) begin
                        n_mode = MODE_NORMAL;
                    end
                end else begin
                    n_elapsed = '0;
                end
            end
            CMD_APP_ON: begin
                n_app    = 1'b1;
                n_tmr_on = 1'b0;
            end
            CMD_APP_OFF: begin
                n_app = 1'b0;
            end
            default: begin
            end
        endcase
    end

    gfsi_rem u_rem (
        .i_limit   (r_fire_lim),
        .i_elapsed (n_elapsed),
        .o_sec     (rem_sec)
    );

    // result from updated state
    always_comb begin
        n_stat    = ST_OK;
        n_red_led = 1'b0;
        n_yel_led = 1'b0;
        n_grn_led = 1'b0;
        fire_cnt  = 1'b0;
        unique case (n_mode)
            MODE_NORMAL: begin
                if (n_app) begin
                    n_stat    = ST_APP_TIMER;
                    n_yel_led = 1'b1;
                end else if (n_tmr_on) begin
                    n_stat    = ST_FIRE_COUNT;
                    fire_cnt  = 1'b1;
                    n_yel_led = n_yel;
                end else begin
                    n_grn_led = 1'b1;
                end
            end
            MODE_APP: begin
                n_stat    = ST_APP_ALERT;
                n_yel_led = 1'b1;
            end
            default: begin
                n_stat    = t_status'(n_mode);
                n_red_led = n_red;
            end
        endcase
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_thr  <= GAS_THR_RST;
            r_fire_lim <= FIRE_LIM_RST;
            r_fast_ms  <= FAST_BLNK_RST;
            r_slow_ms  <= SLOW_BLNK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                CFG_GAS_THR:   r_gas_thr  <= i_cfg.data[GAS_W-1:0];
                CFG_FIRE_LIM:  r_fire_lim <= i_cfg.data[MS_W-1:0];
                CFG_FAST_BLNK: r_fast_ms  <= i_cfg.data[BLINK_W-1:0];
                CFG_SLOW_BLNK: r_slow_ms  <= i_cfg.data[BLINK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_cmd      <= i_req.cmd;
            r_gas_in   <= i_req.gas_level;
            r_flame_in <= i_req.flame_seen;
            r_pres_in  <= i_req.person_present;
        end
    end

    // interlock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_valve   <= 1'b0;
            r_tmr_on  <= 1'b0;
            r_app     <= 1'b0;
            r_elapsed <= '0;
            r_gas     <= '0;
            r_flame   <= 1'b0;
            r_pres    <= 1'b0;
            r_fast    <= '0;
            r_slow    <= '0;
            r_red     <= 1'b0;
            r_yel     <= 1'b0;
        end else if (adv) begin
            r_mode    <= n_mode;
            r_valve   <= n_valve;
            r_tmr_on  <= n_tmr_on;
            r_app     <= n_app;
            r_elapsed <= n_elapsed;
            r_gas     <= n_gas;
            r_flame   <= n_flame;
            r_pres    <= n_pres;
            r_fast    <= n_fast;
            r_slow    <= n_slow;
            r_red     <= n_red;
            r_yel     <= n_yel;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_valve <= n_valve;
            r_o_mode  <= n_mode;
            r_o_stat  <= n_stat;
            r_o_sec   <= fire_cnt ? rem_sec : '0;
            r_o_red   <= n_red_led;
            r_o_yel   <= n_yel_led;
            r_o_grn   <= n_grn_led;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.valve_open  = r_o_valve;
    assign o_rsp.mode        = r_o_mode;
    assign o_rsp.status_code = r_o_stat;
    assign o_rsp.remaining_s = r_o_sec;
    assign o_rsp.red_led     = r_o_red;
    assign o_rsp.yellow_led  = r_o_yel;
    assign o_rsp.green_led   = r_o_grn;

    // valve can only be open in normal mode
    a_valve_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valve |-> r_mode == MODE_NORMAL)
        else $error("valve open outside normal mode");

    // app timer suppresses the fire timer
    a_app_tmr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_app && r_tmr_on))
        else $error("fire timer running with app timer on");

    a_rem_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_o_sec != '0) |-> r_o_stat == ST_FIRE_COUNT)
        else $error("remaining seconds outside fire counting");

    a_red_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_o_red) |-> (r_o_mode == MODE_GAS || r_o_mode == MODE_FIRE))
        else $error("red lamp outside alarm");

    // state only moves when a request completes
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_mode) && $stable(r_elapsed))
        else $error("state changed without a request");

endmodule
`default_nettype wire

// ----- dv/tb_gas_fire_shutoff_interlock.sv -----
// Testbench for the gas and fire shutoff interlock: directed and random requests checked
// against a cycle-free predictor of valve, mode, status, countdown and lamps.
`timescale 1ns / 1ps
module tb_gas_fire_shutoff_interlock;
    import gfsi_pkg::*;

    localparam int unsigned GAS_MAX        = (1 << GAS_W) - 1;
    localparam int unsigned MS_PER_S       = 1000;
    localparam int unsigned PIPE_LAT       = 1;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic    valve;
        t_mode   mode;
        t_status status;
        t_sec    remaining;
        logic    red;
        logic    yellow;
        logic    green;
    } panel_t;

    logic i_clk;
    logic i_rst_n;

    gfsi_in_if  req_if();
    gfsi_out_if rsp_if();
    gfsi_cfg_if cfg_if();

    gas_fire_shutoff_interlock i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // predicted configuration and interlock state
    t_gas   gas_thr     = GAS_THR_RST;
    t_ms    fire_lim    = FIRE_LIM_RST;
    t_blink fast_period = FAST_BLNK_RST;
    t_blink slow_period = SLOW_BLNK_RST;
    t_mode  st_mode     = MODE_NORMAL;
    logic   st_valve    = 1'b0;
    logic   timer_run   = 1'b0;
    logic   app_hold    = 1'b0;
    t_ms    elapsed_ms  = '0;
    t_gas   seen_gas    = '0;
    logic   seen_flame  = 1'b0;
    logic   seen_person = 1'b0;
    t_blink fast_cnt    = '0;
    t_blink slow_cnt    = '0;
    logic   red_ph      = 1'b0;
    logic   yel_ph      = 1'b0;

    panel_t      expected_panel_q[$];
    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned reqs_sent   = 0;

    int unsigned burst_left  = 0;
    int unsigned gap_max     = 0;
    int unsigned burst_max   = 1;
    logic        rx_stall_en = 1'b0;
    logic [15:0] stall_pat   = 16'hB5C3;
    int unsigned pat_age     = 0;

    function automatic panel_t interlock_step(t_cmd cmd, t_gas gas, logic flame,
                                              logic person);
        panel_t p;
        logic   raised;
        p = '0;
        raised = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (timer_run && elapsed_ms < fire_lim) elapsed_ms = elapsed_ms + 1'b1;
                if (st_mode == MODE_GAS || st_mode == MODE_FIRE) begin
                    fast_cnt = fast_cnt + 1'b1;
                    if (fast_cnt >= fast_period) begin
                        fast_cnt = '0;
                        red_ph = ~red_ph;
                    end
                end else if (st_mode == MODE_NORMAL && !app_hold && timer_run) begin
                    slow_cnt = slow_cnt + 1'b1;
                    if (slow_cnt >= slow_period) begin
                        slow_cnt = '0;
                        yel_ph = ~yel_ph;
                    end
                end
            end
            CMD_SAMPLE: begin
                seen_gas = gas;
                seen_flame = flame;
                seen_person = person;
                if (st_mode == MODE_GAS || st_mode == MODE_FIRE) begin
                    st_valve = 1'b0;
                end else if (seen_gas > gas_thr) begin
                    st_mode = MODE_GAS;
                    st_valve = 1'b0;
                end else begin
                    if (seen_flame && !seen_person && !app_hold) begin
                        if (!timer_run) begin
                            elapsed_ms = '0;
                            timer_run = 1'b1;
                        end else if (elapsed_ms >= fire_lim) begin
                            st_mode = MODE_FIRE;
                            st_valve = 1'b0;
                            raised = 1'b1;
                        end
                    end else begin
                        timer_run = 1'b0;
                    end
                    if (!raised) begin
                        if (st_mode == MODE_APP) begin
                            st_valve = 1'b0;
                        end else begin
                            st_mode = MODE_NORMAL;
                            st_valve = 1'b1;
                        end
                    end
                end
            end
            CMD_CLOSE: begin
                st_valve = 1'b0;
                st_mode = MODE_APP;
            end
            CMD_OPEN: begin
                if (st_mode == MODE_GAS) begin
                    if (seen_gas < gas_thr) st_mode = MODE_NORMAL;
                end else if (st_mode != MODE_FIRE) begin
                    st_mode = MODE_NORMAL;
                end
            end
            CMD_TMR_RESET: begin
                if (st_mode == MODE_FIRE) begin
                    if (!seen_flame || seen_person) st_mode = MODE_NORMAL;
                end else begin
                    elapsed_ms = '0;
                end
            end
            CMD_APP_ON: begin
                app_hold = 1'b1;
                timer_run = 1'b0;
            end
            CMD_APP_OFF: app_hold = 1'b0;
            default: ;
        endcase

        if (st_mode == MODE_NORMAL) begin
            if (app_hold) begin
                p.status = ST_APP_TIMER;
                p.yellow = 1'b1;
            end else if (timer_run) begin
                p.status = ST_FIRE_COUNT;
                if (elapsed_ms < fire_lim)
                    p.remaining = t_sec'((fire_lim - elapsed_ms) / MS_PER_S);
                p.yellow = yel_ph;
            end else begin
                p.status = ST_OK;
                p.green = 1'b1;
            end
        end else if (st_mode == MODE_APP) begin
            p.status = ST_APP_ALERT;
            p.yellow = 1'b1;
        end else begin
            p.status = t_status'(st_mode);
            p.red = red_ph;
        end
        p.valve = st_valve;
        p.mode = st_mode;
        return p;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : monitor
        panel_t want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.addr)
                    CFG_GAS_THR:   gas_thr = cfg_if.data[GAS_W-1:0];
                    CFG_FIRE_LIM:  fire_lim = cfg_if.data[MS_W-1:0];
                    CFG_FAST_BLNK: fast_period = cfg_if.data[BLINK_W-1:0];
                    CFG_SLOW_BLNK: slow_period = cfg_if.data[BLINK_W-1:0];
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready)
                expected_panel_q.push_back(interlock_step(req_if.cmd, req_if.gas_level,
                                                          req_if.flame_seen,
                                                          req_if.person_present));
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_panel_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_panel_q.pop_front();
                    check_field("valve_open", 32'(want.valve), 32'(rsp_if.valve_open));
                    check_field("mode", 32'(want.mode), 32'(rsp_if.mode));
                    check_field("status_code", 32'(want.status), 32'(rsp_if.status_code));
                    check_field("remaining_s", 32'(want.remaining), 32'(rsp_if.remaining_s));
                    check_field("red_led", 32'(want.red), 32'(rsp_if.red_led));
                    check_field("yellow_led", 32'(want.yellow), 32'(rsp_if.yellow_led));
                    check_field("green_led", 32'(want.green), 32'(rsp_if.green_led));
                end
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // result-side back-pressure
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pat_age++;
            if (pat_age == 48) begin
                pat_age = 0;
                stall_pat = 16'($urandom) | 16'h0001;
            end
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            rsp_if.ready <= !rx_stall_en || stall_pat[0];
        end
    end

    task automatic send_req(t_cmd cmd, t_gas gas, logic flame, logic person);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.cmd <= cmd;
        req_if.gas_level <= gas;
        req_if.flame_seen <= flame;
        req_if.person_present <= person;
        do @(posedge i_clk); while (!req_if.ready);
        reqs_sent++;
    endtask

    task automatic send_cmd(t_cmd cmd);
        send_req(cmd, t_gas'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // stop sending until every outstanding request has its result
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_panel_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(t_addr addr, t_data data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr <= addr;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_limits(t_data thr, t_data lim, t_data fast, t_data slow);
        settle();
        write_reg(CFG_GAS_THR, thr);
        write_reg(CFG_FIRE_LIM, lim);
        write_reg(CFG_FAST_BLNK, fast);
        write_reg(CFG_SLOW_BLNK, slow);
    endtask

    task automatic set_idle(int unsigned gaps, int unsigned bursts, logic stalls);
        gap_max = gaps;
        burst_max = bursts;
        rx_stall_en = stalls;
    endtask

    function automatic t_gas pick_gas(logic above);
        int unsigned t;
        t = 32'(gas_thr);
        if (above) begin
            case ($urandom_range(0, 3))
                0: return t_gas'(t);
                1: return (t == GAS_MAX) ? t_gas'(t) : t_gas'(t + 1);
                2: return '1;
                default: return t_gas'($urandom_range(t, GAS_MAX));
            endcase
        end
        case ($urandom_range(0, 3))
            0: return t_gas'(t);
            1: return (t == 0) ? '0 : t_gas'(t - 1);
            2: return '0;
            default: return t_gas'($urandom_range(0, t));
        endcase
        return '0;
    endfunction

    task automatic run_random(int unsigned n_items);
        int unsigned target;
        int unsigned k;
        target = reqs_sent + n_items;
        while (reqs_sent < target) begin
            k = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // flame with nobody around, then time passes toward the limit
                    send_req(CMD_SAMPLE, pick_gas(1'b0), 1'b1, 1'b0);
                    repeat (k) send_cmd(CMD_TICK);
                    send_req(CMD_SAMPLE, pick_gas($urandom_range(0, 9) == 0), 1'b1,
                             $urandom_range(0, 7) == 0);
                    repeat ($urandom_range(0, 4)) send_cmd(CMD_TICK);
                    if ($urandom_range(0, 2) == 0) begin
                        send_cmd(CMD_TMR_RESET);
                        send_req(CMD_SAMPLE, pick_gas(1'b0), 1'($urandom_range(0, 1)), 1'b1);
                        send_cmd(CMD_TMR_RESET);
                    end
                end
                4, 5: begin
                    send_req(CMD_SAMPLE, pick_gas(1'b1), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                    repeat (k) send_cmd(CMD_TICK);
                    send_cmd(CMD_OPEN);
                    send_req(CMD_SAMPLE, pick_gas(1'b0), 1'b0, 1'($urandom_range(0, 1)));
                    send_cmd(CMD_OPEN);
                    send_req(CMD_SAMPLE, pick_gas(1'b0), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                end
                6: begin
                    send_cmd($urandom_range(0, 1) ? CMD_APP_ON : CMD_CLOSE);
                    repeat (k) begin
                        if ($urandom_range(0, 2) == 0)
                            send_req(CMD_SAMPLE, pick_gas($urandom_range(0, 5) == 0),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        else
                            send_cmd(CMD_TICK);
                    end
                    send_cmd(CMD_APP_OFF);
                    send_cmd(CMD_OPEN);
                end
                default: begin
                    repeat (k) send_cmd(t_cmd'($urandom));
                end
            endcase
        end
    endtask

    task automatic test_alarm_paths();
        set_idle(3, 6, 1'b1);
        send_cmd(CMD_TICK);
        send_req(CMD_SAMPLE, '0, 1'b0, 1'b0);
        send_req(CMD_SAMPLE, '1, 1'b0, 1'b0);
        send_cmd(CMD_OPEN);
        send_req(CMD_SAMPLE, GAS_THR_RST, 1'b0, 1'b0);
        send_cmd(CMD_OPEN);
        send_req(CMD_SAMPLE, GAS_THR_RST - 1'b1, 1'b0, 1'b0);
        send_cmd(CMD_OPEN);
        send_req(CMD_SAMPLE, '0, 1'b1, 1'b0);
        send_cmd(CMD_APP_ON);
        send_req(CMD_SAMPLE, '0, 1'b1, 1'b0);
        send_cmd(CMD_APP_OFF);
        send_cmd(CMD_CLOSE);
        send_req(CMD_SAMPLE, '0, 1'b0, 1'b0);
        send_cmd(t_cmd'('1));
        send_cmd(CMD_OPEN);
        send_cmd(CMD_TMR_RESET);
    endtask

    task automatic test_fire_timer();
        // zero blink periods toggle on every tick
        apply_limits(t_data'(GAS_THR_RST), t_data'(2), '0, '0);
        set_idle(0, 1, 1'b0);
        send_req(CMD_SAMPLE, '0, 1'b1, 1'b0);
        repeat (3) send_cmd(CMD_TICK);
        send_req(CMD_SAMPLE, '0, 1'b1, 1'b0);
        repeat (2) send_cmd(CMD_TICK);
        send_cmd(CMD_OPEN);
        send_cmd(CMD_TMR_RESET);
        send_req(CMD_SAMPLE, '0, 1'b1, 1'b1);
        send_cmd(CMD_TMR_RESET);
        // zero limit: fire timer still running, so alarm on the first qualifying sample
        settle();
        write_reg(CFG_FIRE_LIM, '0);
        send_req(CMD_SAMPLE, '0, 1'b1, 1'b0);
        send_req(CMD_SAMPLE, '0, 1'b1, 1'b0);
        send_req(CMD_SAMPLE, '0, 1'b0, 1'b0);
        send_cmd(CMD_TMR_RESET);
    endtask

    task automatic test_threshold_extremes();
        apply_limits('0, '0, t_data'(1), t_data'(1));
        set_idle(4, 10, 1'b1);
        run_random(250);
        apply_limits(t_data'(GAS_MAX), '1, t_data'(GAS_MAX), t_data'(GAS_MAX));
        set_idle(0, 1, 1'b0);
        run_random(250);
    endtask

    task automatic test_random_traffic();
        apply_limits(t_data'($urandom_range(200, 3800)), t_data'($urandom_range(0, 40)),
                     t_data'($urandom_range(1, 6)), t_data'($urandom_range(1, 6)));
        set_idle(6, 16, 1'b1);
        run_random(240);
        settle();
        set_idle(2, 30, 1'b0);
        run_random(240);
        apply_limits(t_data'($urandom_range(0, GAS_MAX)), t_data'($urandom_range(0, 30)),
                     t_data'($urandom_range(1, 4)), t_data'($urandom_range(1, 4)));
        set_idle(8, 4, 1'b1);
        run_random(480);
        apply_limits(t_data'($urandom), t_data'($urandom), t_data'($urandom),
                     t_data'($urandom));
        set_idle(3, 8, 1'b1);
        run_random(480);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_TICK;
        req_if.gas_level = '0;
        req_if.flame_seen = 1'b0;
        req_if.person_present = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = CFG_GAS_THR;
        cfg_if.data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_alarm_paths();
        test_fire_timer();
        test_threshold_extremes();
        test_random_traffic();

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_panel_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/gfsi_pkg.sv
design/gfsi_if.sv
design/gfsi_rem.sv
design/gas_fire_shutoff_interlock.sv
dv/tb_gas_fire_shutoff_interlock.sv
